// ===== src/dcbpd_pkg.sv =====
`default_nettype none

package dcbpd_pkg;

    // Fixed-point scaling of the filter: pole = 1 - coef / 2^SHIFT_BITS.
    localparam int SHIFT_BITS = 15;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 10;
    localparam int FILT_W   = 18;
    localparam int ACC_W    = 40;
    localparam int QUOT_W   = ACC_W - SHIFT_BITS;
    localparam int CNT_W    = 32;
    localparam int ENERGY_W = 48;

    localparam int FILT_MAX = 2 ** (FILT_W - 1) - 1;
    localparam int FILT_MIN = -(2 ** (FILT_W - 1));

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 4;
    localparam logic [COEF_W-1:0] POLE_COEF_RESET = COEF_W'(32);

    typedef enum logic [1:0] {
        REG_POLE_COEF  = 2'd0,
        REG_THRESHOLD  = 2'd1,
        REG_MIN_LENGTH = 2'd2
    } t_reg_idx;

    typedef logic [SAMPLE_W-1:0]        t_sample;
    typedef logic signed [FILT_W-1:0]   t_filt;
    typedef logic [CNT_W-1:0]           t_count;
    typedef logic [ENERGY_W-1:0]        t_energy;

endpackage

`default_nettype wire

// ===== src/dcbpd_sample_if.sv =====
`default_nettype none

interface dcbpd_sample_if;
    logic                 valid;
    logic                 ready;
    dcbpd_pkg::t_sample   sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== src/dcbpd_pulse_if.sv =====
`default_nettype none

interface dcbpd_pulse_if;
    logic                 valid;
    logic                 ready;
    dcbpd_pkg::t_count    pulse_start;
    dcbpd_pkg::t_count    pulse_length;
    dcbpd_pkg::t_energy   pulse_energy;
    dcbpd_pkg::t_filt     pulse_peak;

    modport source (output valid, output pulse_start, output pulse_length,
                    output pulse_energy, output pulse_peak, input ready);
    modport sink (input valid, input pulse_start, input pulse_length,
                  input pulse_energy, input pulse_peak, output ready);
endinterface

`default_nettype wire

// ===== src/dc_block_pulse_detector_core.sv =====
// DC blocker with threshold pulse detection.
// Each item on i_sample carries one unsigned 16-bit converter sample. The
// samples pass through a noise-shaped fixed-point DC blocking filter, and the
// filtered level is compared with the threshold register. A run of samples
// above the threshold forms a pulse; when the level falls back, one item
// holding the pulse's start count, length, saturated energy and peak goes out
// on o_pulse, provided the length reaches min_length. Most samples therefore
// give no output item at all.
// An accepted sample is held in an input register and is filtered and
// classified once the output register is free; any result is registered in
// the output register, which drives o_pulse. One sample is accepted in
// every cycle while the output is not stalled; the rate is set by the filter
// recursion (one 10 x 18 multiply and a 40-bit accumulate), which is
// combinational.
// When the receiver stalls, the result waits in the output register; the
// input register still takes a sample, and intake stops only when a filtered
// sample cannot move on because the output register is still full.
// Reset (synchronous, active low) clears the filter, the pulse tracker and the
// sample counter, and sets pole_coef to 32, threshold and min_length to zero.
// The APB port holds pole_coef at 0x0, threshold at 0x4 and min_length at 0x8;
// registers should only be written while no sample is in flight.

`default_nettype none

module dc_block_pulse_detector_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    dcbpd_sample_if.sink                             i_sample,
    dcbpd_pulse_if.source                            o_pulse,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dcbpd_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [dcbpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [dcbpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready
);

    localparam int ACC_W    = dcbpd_pkg::ACC_W;
    localparam int SHIFT    = dcbpd_pkg::SHIFT_BITS;
    localparam int QUOT_W   = dcbpd_pkg::QUOT_W;
    localparam int FILT_W   = dcbpd_pkg::FILT_W;
    localparam int COEF_W   = dcbpd_pkg::COEF_W;
    localparam int ENERGY_W = dcbpd_pkg::ENERGY_W;
    localparam int CNT_W    = dcbpd_pkg::CNT_W;
    localparam int PROD_W   = COEF_W + FILT_W + 1;
    localparam int ESUM_W   = ENERGY_W + 2;

    localparam logic signed [QUOT_W-1:0] Q_MAX = QUOT_W'(dcbpd_pkg::FILT_MAX);
    localparam logic signed [QUOT_W-1:0] Q_MIN = QUOT_W'(dcbpd_pkg::FILT_MIN);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COEF_W-1:0]        r_pole_coef;
    dcbpd_pkg::t_filt         r_threshold;
    dcbpd_pkg::t_count        r_min_length;
    logic                     w_cfg_write;
    dcbpd_pkg::t_reg_idx      w_reg_idx;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_reg_idx   = dcbpd_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_coef  <= dcbpd_pkg::POLE_COEF_RESET;
            r_threshold  <= '0;
            r_min_length <= '0;
        end else if (w_cfg_write) begin
            case (w_reg_idx)
                dcbpd_pkg::REG_POLE_COEF:  r_pole_coef  <= pwdata[COEF_W-1:0];
                dcbpd_pkg::REG_THRESHOLD:  r_threshold  <= $signed(pwdata[FILT_W-1:0]);
                dcbpd_pkg::REG_MIN_LENGTH: r_min_length <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            dcbpd_pkg::REG_POLE_COEF:  prdata = dcbpd_pkg::APB_DATA_W'(r_pole_coef);
            dcbpd_pkg::REG_THRESHOLD:  prdata = dcbpd_pkg::APB_DATA_W'(r_threshold);
            dcbpd_pkg::REG_MIN_LENGTH: prdata = dcbpd_pkg::APB_DATA_W'(r_min_length);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: the input register advances whenever it is empty, or the
    // output register is empty or being emptied this cycle.
    // ------------------------------------------------------------------
    logic                     r_in_valid;
    dcbpd_pkg::t_sample       r_sample;
    logic                     r_out_valid;
    logic                     w_out_free;
    logic                     w_proc;

    assign w_out_free     = !r_out_valid || o_pulse.ready;
    assign w_proc         = r_in_valid && w_out_free;
    assign i_sample.ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_sample <= i_sample.sample;
        end
    end

    // ------------------------------------------------------------------
    // Filter and pulse state
    // ------------------------------------------------------------------
    logic [ACC_W-1:0]         r_acc;
    dcbpd_pkg::t_sample       r_last_sample;
    dcbpd_pkg::t_filt         r_last_filt;
    logic                     r_inside;
    dcbpd_pkg::t_count        r_start;
    dcbpd_pkg::t_filt         r_peak;
    dcbpd_pkg::t_energy       r_energy;
    dcbpd_pkg::t_count        r_count;

    logic signed [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]         n_acc;
    logic signed [QUOT_W-1:0] w_quot;
    logic                     w_round;
    logic signed [QUOT_W-1:0] w_quot_tz;
    dcbpd_pkg::t_filt         w_filt;
    logic                     w_above;
    logic signed [ESUM_W-1:0] w_esum;
    dcbpd_pkg::t_energy       n_energy;
    dcbpd_pkg::t_filt         n_peak;
    dcbpd_pkg::t_count        w_len;
    logic                     w_report;

    // Feedback of the previous filtered value through the pole coefficient.
    assign w_prod = $signed({1'b0, r_pole_coef}) * r_last_filt;

    // The scaled-input terms are the samples shifted up; only the raw
    // samples are kept, which holds the same information.
    assign n_acc = r_acc
                 - ACC_W'({r_last_sample, {SHIFT{1'b0}}})
                 + ACC_W'({r_sample, {SHIFT{1'b0}}})
                 - ACC_W'(w_prod);

    // Division by 2^SHIFT truncating towards zero: an arithmetic shift
    // rounds down, so a negative value with a non-zero remainder gets one
    // added back.
    assign w_quot    = $signed(n_acc[ACC_W-1:SHIFT]);
    assign w_round   = n_acc[ACC_W-1] && (|n_acc[SHIFT-1:0]);
    assign w_quot_tz = w_quot + $signed({{(QUOT_W-1){1'b0}}, w_round});

    always_comb begin
        if (w_quot_tz > Q_MAX) begin
            w_filt = dcbpd_pkg::t_filt'(dcbpd_pkg::FILT_MAX);
        end else if (w_quot_tz < Q_MIN) begin
            w_filt = dcbpd_pkg::t_filt'(dcbpd_pkg::FILT_MIN);
        end else begin
            w_filt = w_quot_tz[FILT_W-1:0];
        end
    end

    assign w_above = w_filt > r_threshold;

    // Energy is a signed running sum clamped to the unsigned 48-bit range at
    // every step; a new pulse starts the sum from zero.
    always_comb begin
        w_esum = $signed({2'b00, (r_inside ? r_energy : {ENERGY_W{1'b0}})})
               + ESUM_W'(w_filt);
        if (w_esum[ESUM_W-1]) begin
            n_energy = '0;
        end else if (w_esum[ENERGY_W]) begin
            n_energy = '1;
        end else begin
            n_energy = w_esum[ENERGY_W-1:0];
        end
    end

    assign n_peak   = (!r_inside || (w_filt > r_peak)) ? w_filt : r_peak;
    assign w_len    = r_count - r_start;
    assign w_report = r_inside && !w_above && (w_len >= r_min_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= '0;
            r_last_sample <= '0;
            r_last_filt   <= '0;
            r_inside      <= 1'b0;
            r_start       <= '0;
            r_peak        <= '0;
            r_energy      <= '0;
            r_count       <= '0;
        end else if (w_proc) begin
            r_acc         <= n_acc;
            r_last_sample <= r_sample;
            r_last_filt   <= w_filt;
            r_count       <= r_count + CNT_W'(1);
            r_inside      <= w_above;
            if (w_above) begin
                if (!r_inside) begin
                    r_start <= r_count;
                end
                r_peak   <= n_peak;
                r_energy <= n_energy;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    dcbpd_pkg::t_count        r_out_start;
    dcbpd_pkg::t_count        r_out_length;
    dcbpd_pkg::t_energy       r_out_energy;
    dcbpd_pkg::t_filt         r_out_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && w_report) begin
            r_out_valid <= 1'b1;
        end else if (o_pulse.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_report) begin
            r_out_start  <= r_start;
            r_out_length <= w_len;
            r_out_energy <= r_energy;
            r_out_peak   <= r_peak;
        end
    end

    assign o_pulse.valid        = r_out_valid;
    assign o_pulse.pulse_start  = r_out_start;
    assign o_pulse.pulse_length = r_out_length;
    assign o_pulse.pulse_energy = r_out_energy;
    assign o_pulse.pulse_peak   = r_out_peak;

`ifndef NO_ASSERTIONS
    // A result only ever comes from a processed sample that closed a pulse.
    a_result_from_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_proc && r_inside && !w_above))
        else $error("result raised without a pulse closing");

    // The sample counter moves by exactly one per processed sample.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> (r_count == CNT_W'($past(r_count) + CNT_W'(1))))
        else $error("sample counter out of step");

    // A held input sample is not overwritten while the output is blocked.
    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_sample)))
        else $error("input register lost a sample");

    // Within a continuing pulse the peak never decreases.
    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_inside && w_above) |=> (r_peak >= $past(r_peak)))
        else $error("pulse peak decreased");
`endif

endmodule

`default_nettype wire
